@@ src/qss_pkg.sv @@
// Package for the qualified string search core: command codes, register
// indexes, mode bit positions and byte classification helpers.
// No dependencies.
package qss_pkg;

   localparam int LINE_MAX_DEF    = 1024;
   localparam int PATTERN_MAX_DEF = 64;

   localparam int CFG_W  = 11;   // widest configuration register
   localparam int COL_W  = 11;   // reported column width
   localparam int CSR_AW = 3;

   // command codes carried in req_tuser
   localparam logic [1:0] CMD_PATTERN = 2'd0;
   localparam logic [1:0] CMD_LINE    = 2'd1;
   localparam logic [1:0] CMD_SEARCH  = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_COUNT  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_WLEFT  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_WRIGHT = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_MLEFT  = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_MRIGHT = 3'd5;

   // mode_flags bit positions
   localparam int MODE_B = 0;
   localparam int MODE_E = 1;
   localparam int MODE_H = 2;
   localparam int MODE_L = 3;
   localparam int MODE_U = 4;
   localparam int MODE_W = 5;
   localparam int MODE_S = 6;
   localparam int MODE_N = 7;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // fold a-z onto A-Z
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      fold_char = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

   // letters, digits and underscore
   function automatic logic is_word_char(input logic [7:0] c);
      is_word_char = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
   endfunction

endpackage

@@ src/qss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/qualified_string_search_core.sv @@
// Qualified string search core: pattern and line stores plus the search sequencer.
// Depends on qss_pkg and qss_ram.
//
// Usage:
//  - req channel: req_tuser carries the command (pattern byte, line byte,
//    search), req_tdata the byte to load, req_tlast the final byte of a
//    pattern or a line. Load beats produce no result.
//  - A search beat produces exactly one rsp beat: rsp_tuser is the found flag,
//    rsp_tdata holds match_begin and match_finish.
//  - csr port: write csr_wdata to register csr_addr when csr_we is high;
//    write only while no search is in flight.
//  - A search runs the optional trim over the line, then a byte-serial compare
//    per candidate column through the single line read port, then the
//    word-boundary check; req_tready is low until the search has finished.
//  - While a result waits unaccepted in the output register, req_tready is
//    low, so a stalled receiver stalls every command, loads included.
//  - Reset clears the lengths, load pointer and registers; the stores keep
//    their contents and need no clearing pass.
module qualified_string_search_core
   import qss_pkg::*;
#(
   parameter int LINE_MAX    = LINE_MAX_DEF,
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic [1:0]        req_tuser,   // [1:0] cmd
   input  logic              req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // [10:0] match_begin, [21:11] match_finish
   output logic              rsp_tuser,   // found
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int LAW    = $clog2(LINE_MAX);
   localparam int PAW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W  = $clog2(LINE_MAX + 1);
   localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
   localparam int BASE_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam int POS_W  = BASE_W + 3;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef enum logic [4:0] {
      S_IDLE, S_TRIML, S_TRIML_CHK, S_TRIMR, S_TRIMR_CHK, S_CLAMP, S_DECIDE,
      S_CAND, S_CMP, S_CMP_CHK, S_WB, S_WB_CHK, S_WA, S_WA_CHK, S_PASS,
      S_FAIL, S_FIN
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [7:0]       mode_ff, count_ff;
   logic [CFG_W-1:0] cwl_ff, cwr_ff, cml_ff, cmr_ff;

   // load state
   logic [LEN_W-1:0]  ptr_ff, ptr_in;
   logic [LEN_W-1:0]  llen_ff, llen_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;

   // search working registers
   pos_type           wl_ff, wl_in, wr_ff, wr_in, lp_ff, lp_in, rp_ff, rp_in;
   pos_type           p_ff, p_in, wlo_ff, wlo_in;
   logic [PLEN_W-1:0] i_ff, i_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic              hit_ff, hit_in, single_ff, single_in, back_ff, back_in;
   logic              uword_ff, uword_in, oob_ff, oob_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic [COL_W-1:0] rsp_b_ff, rsp_b_in, rsp_e_ff, rsp_e_in;

   // store ports
   logic           line_we, pat_we;
   logic [7:0]     line_q, pat_q, line_byte, cmp_a, cmp_b;
   pos_type        col;
   pos_type        len_pos, llen_pos, rp_tmp, lp_tmp, step;
   logic [LEN_W:0] n_next;
   logic           accept, fb, fe, fh, fl, fu, fw, fs, fn, cond, res_hit;

   assign fb = mode_ff[MODE_B];
   assign fe = mode_ff[MODE_E];
   assign fh = mode_ff[MODE_H];
   assign fl = mode_ff[MODE_L];
   assign fu = mode_ff[MODE_U];
   assign fw = mode_ff[MODE_W];
   assign fs = mode_ff[MODE_S];
   assign fn = mode_ff[MODE_N];

   assign len_pos  = pos_type'(plen_ff);
   assign llen_pos = pos_type'(llen_ff);

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign line_we = accept && req_tuser == CMD_LINE && ptr_ff < LEN_W'(LINE_MAX);
   assign pat_we  = accept && req_tuser == CMD_PATTERN &&
                    (LEN_W + 1)'(ptr_ff) < (LEN_W + 1)'(PATTERN_MAX);

   qss_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line_ram (
      .clock (clock),
      .we    (line_we),
      .waddr (ptr_ff[LAW-1:0]),
      .wdata (req_tdata),
      .raddr (col[LAW-1:0]),
      .rdata (line_q)
   );

   qss_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pat_ram (
      .clock (clock),
      .we    (pat_we),
      .waddr (PAW'(ptr_ff)),
      .wdata (req_tdata),
      .raddr (PAW'(i_ff)),
      .rdata (pat_q)
   );

   // columns outside the line read as zero
   assign line_byte = oob_ff ? 8'd0 : line_q;
   assign cmp_a     = fu ? fold_char(pat_q) : pat_q;
   assign cmp_b     = fu ? fold_char(line_byte) : line_byte;
   assign step      = back_ff ? -len_pos : len_pos;
   assign res_hit   = hit_ff ^ fn;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      llen_in      = llen_ff;
      plen_in      = plen_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      lp_in        = lp_ff;
      rp_in        = rp_ff;
      p_in         = p_ff;
      wlo_in       = wlo_ff;
      i_in         = i_ff;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      single_in    = single_ff;
      back_in      = back_ff;
      uword_in     = uword_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_e_in     = rsp_e_ff;
      col          = '0;
      lp_tmp       = '0;
      rp_tmp       = '0;
      cond         = 1'b0;
      n_next       = (LEN_W + 1)'(ptr_ff) + 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == CMD_PATTERN || req_tuser == CMD_LINE) begin
                  if (req_tlast) begin
                     if (req_tuser == CMD_PATTERN) begin
                        plen_in = (n_next > (LEN_W + 1)'(PATTERN_MAX)) ?
                                  PLEN_W'(PATTERN_MAX) : PLEN_W'(n_next);
                     end else begin
                        llen_in = (n_next > (LEN_W + 1)'(LINE_MAX)) ?
                                  LEN_W'(LINE_MAX) : LEN_W'(n_next);
                     end
                     ptr_in = '0;
                  end else if (ptr_ff < LEN_W'(LINE_MAX)) begin
                     ptr_in = ptr_ff + 1'b1;
                  end
               end else if (req_tuser == CMD_SEARCH) begin
                  wl_in    = pos_type'(cwl_ff);
                  wr_in    = (pos_type'(cwr_ff) > llen_pos) ? llen_pos : pos_type'(cwr_ff);
                  cnt_in   = count_ff;
                  hit_in   = 1'b0;
                  state_in = fs ? S_TRIML : S_CLAMP;
               end
            end
         end
         S_TRIML: begin
            col = wl_ff;
            state_in = (wl_ff < wr_ff) ? S_TRIML_CHK : S_TRIMR;
         end
         S_TRIML_CHK: begin
            if (line_byte == SPACE_CHAR) begin
               wl_in    = wl_ff + 1'b1;
               state_in = S_TRIML;
            end else begin
               state_in = S_TRIMR;
            end
         end
         S_TRIMR: begin
            col = wr_ff - 1'b1;
            state_in = (wl_ff < wr_ff) ? S_TRIMR_CHK : S_CLAMP;
         end
         S_TRIMR_CHK: begin
            if (line_byte == SPACE_CHAR) begin
               wr_in    = wr_ff - 1'b1;
               state_in = S_TRIMR;
            end else begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            lp_tmp   = (pos_type'(cml_ff) < wl_ff) ? wl_ff : pos_type'(cml_ff);
            rp_tmp   = (pos_type'(cmr_ff) > wr_ff) ? wr_ff : pos_type'(cmr_ff);
            lp_in    = lp_tmp;
            rp_in    = (rp_tmp < lp_tmp) ? lp_tmp : rp_tmp;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            single_in = 1'b1;
            back_in   = 1'b0;
            uword_in  = fw;
            wlo_in    = wl_ff;
            p_in      = lp_ff;
            state_in  = S_FIN;
            if (lp_ff + len_pos <= rp_ff) begin
               priority if (fb) begin
                  if (lp_ff == wl_ff || fh) begin
                     if (fe) begin
                        uword_in = 1'b0;
                        if (len_pos == rp_ff - lp_ff) state_in = S_CAND;
                     end else begin
                        wlo_in   = lp_ff;
                        state_in = S_CAND;
                     end
                  end
               end else if (fe) begin
                  if (rp_ff == wr_ff) begin
                     p_in     = rp_ff - len_pos;
                     state_in = S_CAND;
                  end
               end else if (fh) begin
                  state_in = S_CAND;
               end else begin
                  single_in = 1'b0;
                  back_in   = fl;
                  if (fl) p_in = rp_ff - len_pos;
                  // an empty pattern matches at once
                  if (plen_ff == '0) hit_in = 1'b1;
                  else state_in = S_CAND;
               end
            end
         end
         S_CAND: begin
            cond     = back_ff ? (p_ff >= lp_ff) : (p_ff + len_pos <= rp_ff);
            i_in     = '0;
            state_in = (single_ff || cond) ? S_CMP : S_FIN;
         end
         S_CMP: begin
            col = p_ff + pos_type'(i_ff);
            state_in = (i_ff == plen_ff) ? S_WB : S_CMP_CHK;
         end
         S_CMP_CHK: begin
            if (cmp_a == cmp_b) begin
               i_in     = i_ff + 1'b1;
               state_in = S_CMP;
            end else begin
               state_in = S_FAIL;
            end
         end
         S_WB: begin
            col = p_ff - 1'b1;
            priority if (!uword_ff) state_in = S_PASS;
            else if (p_ff > wlo_ff) state_in = S_WB_CHK;
            else state_in = S_WA;
         end
         S_WB_CHK: begin
            state_in = is_word_char(line_byte) ? S_FAIL : S_WA;
         end
         S_WA: begin
            col = p_ff + len_pos;
            state_in = (p_ff + len_pos < wr_ff) ? S_WA_CHK : S_PASS;
         end
         S_WA_CHK: begin
            state_in = is_word_char(line_byte) ? S_FAIL : S_PASS;
         end
         S_PASS: begin
            if (single_ff || cnt_ff <= 8'd1) begin
               hit_in   = 1'b1;
               state_in = S_FIN;
            end else begin
               // skip past this occurrence
               cnt_in   = cnt_ff - 1'b1;
               p_in     = p_ff + step;
               state_in = S_CAND;
            end
         end
         S_FAIL: begin
            if (single_ff) begin
               state_in = S_FIN;
            end else begin
               p_in     = back_ff ? p_ff - 1'b1 : p_ff + 1'b1;
               state_in = S_CAND;
            end
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_found_in = res_hit;
            priority if (!res_hit) begin
               rsp_b_in = '0;
               rsp_e_in = '0;
            end else if (fn) begin
               rsp_b_in = '0;
               rsp_e_in = COL_W'(llen_ff);
            end else begin
               rsp_b_in = COL_W'(p_ff);
               rsp_e_in = COL_W'(p_ff + len_pos);
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign oob_in = (col < 0) || (col >= llen_pos);

   always_ff @(posedge clock) begin
      // payload, no reset needed
      wl_in_hold: begin
         wl_ff     <= wl_in;
         wr_ff     <= wr_in;
         lp_ff     <= lp_in;
         rp_ff     <= rp_in;
         p_ff      <= p_in;
         wlo_ff    <= wlo_in;
         i_ff      <= i_in;
         cnt_ff    <= cnt_in;
         hit_ff    <= hit_in;
         single_ff <= single_in;
         back_ff   <= back_in;
         uword_ff  <= uword_in;
         oob_ff    <= oob_in;
         rsp_found_ff <= rsp_found_in;
         rsp_b_ff  <= rsp_b_in;
         rsp_e_ff  <= rsp_e_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         llen_ff      <= '0;
         plen_ff      <= '0;
         mode_ff      <= 8'd0;
         count_ff     <= 8'd1;
         cwl_ff       <= '0;
         cwr_ff       <= CFG_W'(1024);
         cml_ff       <= '0;
         cmr_ff       <= CFG_W'(1024);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         llen_ff      <= llen_in;
         plen_ff      <= plen_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MODE:   mode_ff  <= csr_wdata[7:0];
               CSR_COUNT:  count_ff <= csr_wdata[7:0];
               CSR_WLEFT:  cwl_ff   <= csr_wdata;
               CSR_WRIGHT: cwr_ff   <= csr_wdata;
               CSR_MLEFT:  cml_ff   <= csr_wdata;
               CSR_MRIGHT: cmr_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {2'b00, rsp_e_ff, rsp_b_ff};

   // a miss reports zero columns
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero columns");

   // no request is taken while the sequencer is busy
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("ready while searching");

   // the compare index never runs past the pattern
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP || state_ff == S_CMP_CHK |-> i_ff <= plen_ff)
      else $error("pattern index overrun");

   // a result appears only out of the finish step
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_FIN))
      else $error("result without a finished search");

endmodule
